@@ src/ssc_pkg.sv @@
// ssc_pkg: shared types, constants and helpers for the stream side classifier
// holds the d8 offset tables, the cross-product helper and the cell payload type
// no dependencies
package ssc_pkg;

  localparam int unsigned NumNbr   = 8;
  localparam int unsigned DirW     = 3;
  localparam int unsigned NbrDirsW = NumNbr * DirW;

  typedef logic [DirW-1:0]     dir_t;
  typedef logic signed [1:0]   ofs_t;
  typedef logic signed [3:0]   zval_t;

  // d8 direction codes, north first, clockwise
  typedef enum logic [DirW-1:0] {
    DIR_N  = 3'd0,
    DIR_NE = 3'd1,
    DIR_E  = 3'd2,
    DIR_SE = 3'd3,
    DIR_S  = 3'd4,
    DIR_SW = 3'd5,
    DIR_W  = 3'd6,
    DIR_NW = 3'd7
  } d8_t;

  // half turn in direction codes
  localparam dir_t HalfTurn = 3'd4;

  // payload handed from cell to cell
  typedef struct packed {
    dir_t                  fdir;
    dir_t                  sdir;
    zval_t                 za;
    logic [NumNbr-1:0]     nvalid;
    logic [NbrDirsW-1:0]   ndirs;
    logic                  seen;
    logic                  right;
    logic                  done;
  } cell_pay_t;

  // x offset of a d8 direction
  function automatic ofs_t dir_dx(input dir_t d);
    ofs_t r;
    case (d8_t'(d))
      DIR_N:   r = 2'sd0;
      DIR_NE:  r = 2'sd1;
      DIR_E:   r = 2'sd1;
      DIR_SE:  r = 2'sd1;
      DIR_S:   r = 2'sd0;
      DIR_SW:  r = -2'sd1;
      DIR_W:   r = -2'sd1;
      DIR_NW:  r = -2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

  // y offset of a d8 direction
  function automatic ofs_t dir_dy(input dir_t d);
    ofs_t r;
    case (d8_t'(d))
      DIR_N:   r = 2'sd1;
      DIR_NE:  r = 2'sd1;
      DIR_E:   r = 2'sd0;
      DIR_SE:  r = -2'sd1;
      DIR_S:   r = -2'sd1;
      DIR_SW:  r = -2'sd1;
      DIR_W:   r = 2'sd0;
      DIR_NW:  r = 2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

  // z component of the cross product a x b, range -2..2
  function automatic zval_t zcross(input ofs_t ax, input ofs_t ay,
                                   input ofs_t bx, input ofs_t by);
    zval_t ax4;
    zval_t ay4;
    zval_t bx4;
    zval_t by4;
    ax4 = zval_t'(ax);
    ay4 = zval_t'(ay);
    bx4 = zval_t'(bx);
    by4 = zval_t'(by);
    return zval_t'(ax4 * by4 - ay4 * bx4);
  endfunction

endpackage

@@ src/ssc_if.sv @@
// ssc_in_if / ssc_out_if: valid-ready channels of the stream side classifier
// depends on ssc_pkg for field widths
interface ssc_in_if;
  logic                          valid;
  logic                          ready;
  logic [ssc_pkg::DirW-1:0]      flow_dir;
  logic [ssc_pkg::DirW-1:0]      stream_dir;
  logic [ssc_pkg::NumNbr-1:0]    neighbor_valid;
  logic [ssc_pkg::NbrDirsW-1:0]  neighbor_dirs;

  modport source (output valid, flow_dir, stream_dir, neighbor_valid, neighbor_dirs,
                  input ready);
  modport sink   (input valid, flow_dir, stream_dir, neighbor_valid, neighbor_dirs,
                  output ready);
endinterface

interface ssc_out_if;
  logic valid;
  logic ready;
  logic on_left;
  logic on_right;

  modport source (output valid, on_left, on_right, input ready);
  modport sink   (input valid, on_left, on_right, output ready);
endinterface

@@ src/ssc_cell.sv @@
// ssc_cell: one neighbor cell of the classifier chain, one register stage
// examines the lowest pending neighbor and shifts the rest on; uses ssc_pkg
module ssc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ssc_pkg::DirW-1:0]      idx,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  ssc_pkg::cell_pay_t            up_pay,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output ssc_pkg::cell_pay_t            dn_pay
);

  logic                valid_r;
  logic                valid_nxt;
  ssc_pkg::cell_pay_t  pay_r;
  ssc_pkg::cell_pay_t  pay_nxt;

  ssc_pkg::dir_t       back_dir;
  ssc_pkg::ofs_t       tx;
  ssc_pkg::ofs_t       ty;
  ssc_pkg::zval_t      zb;
  ssc_pkg::zval_t      zc;
  logic                trib;
  logic                same_side;
  logic                new_right;

  // stage advances when empty or when the next stage takes its item
  assign up_ready = !valid_r || dn_ready;

  // tributary test and side decision for this neighbor
  always_comb begin
    back_dir  = ssc_pkg::dir_t'(idx + ssc_pkg::HalfTurn);
    tx        = ssc_pkg::dir_dx(back_dir);
    ty        = ssc_pkg::dir_dy(back_dir);
    zb        = ssc_pkg::zcross(ssc_pkg::dir_dx(up_pay.fdir), ssc_pkg::dir_dy(up_pay.fdir),
                                tx, ty);
    zc        = ssc_pkg::zcross(ssc_pkg::dir_dx(up_pay.sdir), ssc_pkg::dir_dy(up_pay.sdir),
                                tx, ty);
    trib      = up_pay.nvalid[0] && (up_pay.ndirs[ssc_pkg::DirW-1:0] == back_dir)
                && !up_pay.done;
    same_side = (zb != 4'sd0) && ((up_pay.za == 4'sd0) || (up_pay.za[3] == zb[3]));
    new_right = same_side ? zb[3] : zc[3];

    pay_nxt        = up_pay;
    pay_nxt.nvalid = up_pay.nvalid >> 1;
    pay_nxt.ndirs  = up_pay.ndirs >> ssc_pkg::DirW;
    if (trib) begin
      if (up_pay.seen && (new_right != up_pay.right)) begin
        // junction between tributaries ends the scan
        pay_nxt.done = 1'b1;
      end else begin
        pay_nxt.right = new_right;
        pay_nxt.seen  = 1'b1;
      end
    end
  end

  // valid flag
  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pay_r <= pay_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_pay   = pay_r;

  // a finished scan stays finished
  a_done_kept: assert property (@(posedge clk) disable iff (!rst_n)
    up_valid && up_ready && up_pay.done |=> pay_r.done)
    else $error("ssc_cell: done flag lost");

  // once a tributary is seen it stays seen
  a_seen_kept: assert property (@(posedge clk) disable iff (!rst_n)
    up_valid && up_ready && up_pay.seen |=> pay_r.seen)
    else $error("ssc_cell: seen flag lost");

  // flow and stream directions pass through unchanged
  a_dirs_kept: assert property (@(posedge clk) disable iff (!rst_n)
    up_valid && up_ready |=> (pay_r.fdir == $past(up_pay.fdir))
                             && (pay_r.sdir == $past(up_pay.sdir)))
    else $error("ssc_cell: directions altered");

endmodule

@@ src/stream_side_classifier_unit.sv @@
// stream_side_classifier_unit: top level of the stream side classifier
// instantiates eight ssc_cell stages; uses ssc_pkg, ssc_in_if and ssc_out_if
//
// usage
//   in_ch carries one flow line item: flow direction, stream cell direction,
//   and the eight neighbor directions with their valid bits. out_ch returns
//   on_left / on_right for that item; both set means the side is undetermined
//   (channel head, line opposing the stream, or a junction between tributaries).
//   items are classified strictly in order, one result per item.
// timing
//   a chain of eight register cells, one per neighbor index, each looking at
//   its neighbor and passing the item on. the result of an item is shown on
//   out_ch from the register of the last cell. one item enters per cycle
//   while the chain is not stalled.
// reset
//   rst_n low clears every cell's valid flag; items in flight are dropped.
// stall
//   each cell holds its item while the next one is full and stalled, so a
//   stalled receiver fills the chain from the end; in_ch.ready drops only
//   when all eight cells hold items.
module stream_side_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  ssc_in_if.sink      in_ch,
  ssc_out_if.source   out_ch
);

  logic               vld [0:ssc_pkg::NumNbr];
  logic               rdy [0:ssc_pkg::NumNbr];
  ssc_pkg::cell_pay_t pay [0:ssc_pkg::NumNbr];

  ssc_pkg::cell_pay_t head_pay;
  logic               fin_both;

  // head: cross product of flow and stream, opposite-direction check
  always_comb begin
    head_pay.fdir   = in_ch.flow_dir;
    head_pay.sdir   = in_ch.stream_dir;
    head_pay.za     = ssc_pkg::zcross(ssc_pkg::dir_dx(in_ch.flow_dir),
                                      ssc_pkg::dir_dy(in_ch.flow_dir),
                                      ssc_pkg::dir_dx(in_ch.stream_dir),
                                      ssc_pkg::dir_dy(in_ch.stream_dir));
    head_pay.nvalid = in_ch.neighbor_valid;
    head_pay.ndirs  = in_ch.neighbor_dirs;
    head_pay.seen   = 1'b0;
    head_pay.right  = 1'b1;
    head_pay.done   = (ssc_pkg::dir_t'(in_ch.flow_dir + ssc_pkg::HalfTurn)
                       == in_ch.stream_dir);
  end

  assign vld[0]      = in_ch.valid;
  assign pay[0]      = head_pay;
  assign in_ch.ready = rdy[0];

  // one cell per neighbor index
  for (genvar g = 0; g < ssc_pkg::NumNbr; g++) begin : g_cell
    ssc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (ssc_pkg::dir_t'(g)),
      .up_valid (vld[g]),
      .up_ready (rdy[g]),
      .up_pay   (pay[g]),
      .dn_valid (vld[g+1]),
      .dn_ready (rdy[g+1]),
      .dn_pay   (pay[g+1])
    );
  end

  // result from the last cell register
  assign fin_both        = pay[ssc_pkg::NumNbr].done || !pay[ssc_pkg::NumNbr].seen;
  assign out_ch.valid    = vld[ssc_pkg::NumNbr];
  assign out_ch.on_left  = fin_both || !pay[ssc_pkg::NumNbr].right;
  assign out_ch.on_right = fin_both || pay[ssc_pkg::NumNbr].right;
  assign rdy[ssc_pkg::NumNbr] = out_ch.ready;

endmodule

@@ tb/stream_side_classifier_unit_test.sv @@
// stream_side_classifier_unit_test: self-checking bench for the stream side classifier
// directed table of flow line items, then random items, both under random stalls but for calm stretches
// depends on ssc_pkg, ssc_in_if / ssc_out_if and stream_side_classifier_unit
module stream_side_classifier_unit_test;

  localparam int NumDirected = 20;
  localparam int NumRandom   = 1650;
  localparam int PauseEvery  = 400;
  localparam int IdleLimit   = 5000;
  localparam int DrainCycles = 24;
  localparam int MaxReported = 10;

  typedef logic [ssc_pkg::NumNbr-1:0]   nvalid_t;
  typedef logic [ssc_pkg::NbrDirsW-1:0] ndirs_t;

  // neighbor i holding the code that points back at the stream cell
  localparam ndirs_t AllBack =
    {ssc_pkg::DIR_SE, ssc_pkg::DIR_E, ssc_pkg::DIR_NE, ssc_pkg::DIR_N,
     ssc_pkg::DIR_NW, ssc_pkg::DIR_W, ssc_pkg::DIR_SW, ssc_pkg::DIR_S};
  // neighbor i pointing away from the stream cell
  localparam ndirs_t AllAway =
    {ssc_pkg::DIR_NW, ssc_pkg::DIR_W, ssc_pkg::DIR_SW, ssc_pkg::DIR_S,
     ssc_pkg::DIR_SE, ssc_pkg::DIR_E, ssc_pkg::DIR_NE, ssc_pkg::DIR_N};

  typedef struct packed {
    logic on_left;
    logic on_right;
  } side_t;

  // one directed row; typed marks a row whose result is written in by hand
  typedef struct packed {
    ssc_pkg::dir_t fdir;
    ssc_pkg::dir_t sdir;
    nvalid_t       nvalid;
    ndirs_t        ndirs;
    logic          typed;
    side_t         side;
  } flow_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;

  ssc_in_if  in_ch ();
  ssc_out_if out_ch ();

  side_t pending_sides [$];
  int    fail_count = 0;
  int    idle_cycles = 0;
  int    sink_hold = 0;

  stream_side_classifier_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // d8 offsets, north first, clockwise
  function automatic void d8_offset(input ssc_pkg::dir_t d, output int dx, output int dy);
    case (ssc_pkg::d8_t'(d))
      ssc_pkg::DIR_N:  begin dx = 0;  dy = 1;  end
      ssc_pkg::DIR_NE: begin dx = 1;  dy = 1;  end
      ssc_pkg::DIR_E:  begin dx = 1;  dy = 0;  end
      ssc_pkg::DIR_SE: begin dx = 1;  dy = -1; end
      ssc_pkg::DIR_S:  begin dx = 0;  dy = -1; end
      ssc_pkg::DIR_SW: begin dx = -1; dy = -1; end
      ssc_pkg::DIR_W:  begin dx = -1; dy = 0;  end
      default:         begin dx = -1; dy = 1;  end
    endcase
  endfunction

  // side of a flow line from the tributaries around the stream cell
  function automatic side_t classify_side(input ssc_pkg::dir_t fdir,
                                          input ssc_pkg::dir_t sdir,
                                          input nvalid_t nvalid,
                                          input ndirs_t ndirs);
    side_t s;
    int fx, fy, sx, sy, tx, ty, za, zb, zc;
    int tribs;
    logic stop;
    logic last_right;
    ssc_pkg::dir_t d;
    s.on_left  = 1'b1;
    s.on_right = 1'b1;
    // line opposing the stream stays undetermined
    if (ssc_pkg::dir_t'(fdir + ssc_pkg::HalfTurn) == sdir) return s;
    d8_offset(fdir, fx, fy);
    d8_offset(sdir, sx, sy);
    za = fx * sy - fy * sx;
    tribs = 0;
    stop = 1'b0;
    for (int i = 0; i < ssc_pkg::NumNbr; i++) begin
      d = ndirs[ssc_pkg::DirW*i +: ssc_pkg::DirW];
      if (!stop && nvalid[i] && d == ssc_pkg::dir_t'(3'(i) + ssc_pkg::HalfTurn)) begin
        tribs++;
        d8_offset(d, tx, ty);
        zb = fx * ty - fy * tx;
        last_right = s.on_right;
        if (za * zb >= 0 && zb != 0) begin
          s.on_right = (zb < 0);
        end else begin
          zc = sx * ty - sy * tx;
          s.on_right = (zc < 0);
        end
        s.on_left = ~s.on_right;
        // junction: the line sits between two tributaries
        if (tribs > 1 && s.on_right != last_right) begin
          s.on_left  = 1'b1;
          s.on_right = 1'b1;
          stop = 1'b1;
        end
      end
    end
    return s;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < MaxReported) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // offer one item and hold it until taken; the expected side is queued on accept
  task automatic drive_item(input ssc_pkg::dir_t fdir, input ssc_pkg::dir_t sdir,
                            input nvalid_t nvalid, input ndirs_t ndirs,
                            input side_t want);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.flow_dir       <= fdir;
    in_ch.stream_dir     <= sdir;
    in_ch.neighbor_valid <= nvalid;
    in_ch.neighbor_dirs  <= ndirs;
    do @(posedge clk); while (!in_ch.ready);
    pending_sides.push_back(want);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    while (pending_sides.size() != 0) @(posedge clk);
  endtask

  // result side: check each item taken, then pick the next ready level
  always @(posedge clk) begin : result_sink
    side_t want;
    side_t got;
    int gap;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.on_left  = out_ch.on_left;
        got.on_right = out_ch.on_right;
        if (pending_sides.size() == 0) begin
          note_failure($sformatf("result with nothing pending: left=%b right=%b",
                                 got.on_left, got.on_right));
        end else begin
          want = pending_sides.pop_front();
          if (got.on_left !== want.on_left)
            note_failure($sformatf("on_left expected %b got %b", want.on_left, got.on_left));
          if (got.on_right !== want.on_right)
            note_failure($sformatf("on_right expected %b got %b",
                                   want.on_right, got.on_right));
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        gap = calm ? 0 : pick_gap();
        if (gap == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          sink_hold = gap - 1;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    flow_row_t directed_rows [NumDirected];
    side_t undet;
    side_t want;
    ssc_pkg::dir_t fd;
    ssc_pkg::dir_t sd;
    nvalid_t nv;
    ndirs_t nd;
    int mode;

    undet = '{on_left: 1'b1, on_right: 1'b1};
    directed_rows = '{
      // all zero fields: only neighbor 4 could point back, and it is invalid
      '{ssc_pkg::DIR_N,  ssc_pkg::DIR_N,  8'h00, 24'h000000, 1'b1, undet},
      '{ssc_pkg::DIR_NW, ssc_pkg::DIR_NW, 8'hFF, 24'hFFFFFF, 1'b0, undet},
      // line opposing the stream
      '{ssc_pkg::DIR_N,  ssc_pkg::DIR_S,  8'hFF, AllBack,    1'b1, undet},
      '{ssc_pkg::DIR_E,  ssc_pkg::DIR_W,  8'hFF, AllBack,    1'b1, undet},
      '{ssc_pkg::DIR_NE, ssc_pkg::DIR_SW, 8'h00, 24'h000000, 1'b1, undet},
      '{ssc_pkg::DIR_SE, ssc_pkg::DIR_NW, 8'h0F, AllBack,    1'b1, undet},
      '{ssc_pkg::DIR_NW, ssc_pkg::DIR_SE, 8'hFF, 24'hFFFFFF, 1'b1, undet},
      // channel head: valid neighbors all point away
      '{ssc_pkg::DIR_NE, ssc_pkg::DIR_E,  8'hFF, AllAway,    1'b1, undet},
      // invalid neighbors ignored, whatever their codes
      '{ssc_pkg::DIR_N,  ssc_pkg::DIR_E,  8'h00, AllBack,    1'b1, undet},
      '{ssc_pkg::DIR_W,  ssc_pkg::DIR_N,  8'h01, AllAway,    1'b1, undet},
      // single tributaries at both ends of the scan
      '{ssc_pkg::DIR_N,  ssc_pkg::DIR_E,  8'h01, AllBack,    1'b0, undet},
      '{ssc_pkg::DIR_N,  ssc_pkg::DIR_E,  8'h80, AllBack,    1'b0, undet},
      // many tributaries, junctions
      '{ssc_pkg::DIR_N,  ssc_pkg::DIR_E,  8'hFF, AllBack,    1'b0, undet},
      '{ssc_pkg::DIR_E,  ssc_pkg::DIR_S,  8'hFF, AllBack,    1'b0, undet},
      '{ssc_pkg::DIR_S,  ssc_pkg::DIR_SE, 8'h11, AllBack,    1'b0, undet},
      '{ssc_pkg::DIR_E,  ssc_pkg::DIR_E,  8'hFF, AllBack,    1'b0, undet},
      '{ssc_pkg::DIR_NW, ssc_pkg::DIR_N,  8'hAA, AllBack,    1'b0, undet},
      '{ssc_pkg::DIR_N,  ssc_pkg::DIR_NW, 8'h55, AllBack,    1'b0, undet},
      '{ssc_pkg::DIR_SE, ssc_pkg::DIR_NE, 8'h3C, 24'hFFFFFF, 1'b0, undet},
      '{ssc_pkg::DIR_SW, ssc_pkg::DIR_W,  8'hC3, AllBack,    1'b0, undet}
    };

    in_ch.valid          <= 1'b0;
    in_ch.flow_dir       <= '0;
    in_ch.stream_dir     <= '0;
    in_ch.neighbor_valid <= '0;
    in_ch.neighbor_dirs  <= '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[k]) begin
      if (directed_rows[k].typed) begin
        want = directed_rows[k].side;
      end else begin
        want = classify_side(directed_rows[k].fdir, directed_rows[k].sdir,
                             directed_rows[k].nvalid, directed_rows[k].ndirs);
      end
      drive_item(directed_rows[k].fdir, directed_rows[k].sdir,
                 directed_rows[k].nvalid, directed_rows[k].ndirs, want);
    end
    in_ch.valid <= 1'b0;
    wait_results();

    // random items, mostly with real tributaries, some opposing or raw
    for (int n = 0; n < NumRandom; n++) begin
      calm <= ((n / 150) % 4 == 1);
      mode = $urandom_range(0, 9);
      fd = ssc_pkg::dir_t'($urandom_range(0, 7));
      sd = ssc_pkg::dir_t'($urandom_range(0, 7));
      nv = nvalid_t'($urandom);
      nd = ndirs_t'($urandom);
      if (mode < 8) begin
        for (int i = 0; i < ssc_pkg::NumNbr; i++) begin
          nv[i] = ($urandom_range(0, 9) < 6);
          if ($urandom_range(0, 9) < 6)
            nd[ssc_pkg::DirW*i +: ssc_pkg::DirW] = ssc_pkg::dir_t'(3'(i) + ssc_pkg::HalfTurn);
        end
      end else if (mode == 8) begin
        sd = ssc_pkg::dir_t'(fd + ssc_pkg::HalfTurn);
      end
      drive_item(fd, sd, nv, nd, classify_side(fd, sd, nv, nd));
      // sender holds off until the chain is empty
      if (n % PauseEvery == PauseEvery - 1) begin
        in_ch.valid <= 1'b0;
        wait_results();
      end
    end
    in_ch.valid <= 1'b0;
    wait_results();
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
